>>> design/ggc_pkg.sv
package ggc_pkg;

    localparam int CORDIC_ITERS_DEF = 14;
    localparam int TAB_LEN          = 24;
    localparam int TAB_IDX_W        = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_RADIUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_WINDOW  = 3'd4;

    localparam logic [15:0] HEADING_GAIN_RST  = 16'd6144;
    localparam logic [15:0] SPEED_GAIN_RST    = 16'd2048;
    localparam logic [15:0] SPEED_LIMIT_RST   = 16'd256;
    localparam logic [15:0] ARRIVE_RADIUS_RST = 16'd128;
    localparam logic [14:0] DRIVE_WINDOW_RST  = 15'd2458;

    localparam logic signed [19:0] PI_Q13     = 20'sd25736;
    localparam logic signed [19:0] TWO_PI_Q13 = 20'sd51472;
    localparam logic signed [34:0] PI_Q30     = 35'sd3373259426;

    typedef struct packed {
        logic load;
        logic mark_step;
        logic set_stop;
        logic cordic_init;
        logic cordic_step;
        logic round_err;
        logic wrap_err;
        logic mult;
        logic finish;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic finished;
        logic dup_step;
        logic stop_cond;
        logic iter_last;
        logic err_high;
        logic err_low;
    } t_dp_stat;

    function automatic logic [29:0] atan_tab(input logic [TAB_IDX_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'h3243F6A8;
            5'd1:    v = 30'h1DAC6705;
            5'd2:    v = 30'h0FADBAFC;
            5'd3:    v = 30'h07F56EA6;
            5'd4:    v = 30'h03FEAB76;
            5'd5:    v = 30'h01FFD55B;
            5'd6:    v = 30'h00FFFAAA;
            5'd7:    v = 30'h007FFF55;
            5'd8:    v = 30'h003FFFEA;
            5'd9:    v = 30'h001FFFFD;
            5'd10:   v = 30'h000FFFFF;
            5'd11:   v = 30'h0007FFFF;
            5'd12:   v = 30'h0003FFFF;
            5'd13:   v = 30'h0001FFFF;
            5'd14:   v = 30'h0000FFFF;
            5'd15:   v = 30'h00007FFF;
            5'd16:   v = 30'h00003FFF;
            5'd17:   v = 30'h00001FFF;
            5'd18:   v = 30'h00000FFF;
            5'd19:   v = 30'h000007FF;
            5'd20:   v = 30'h000003FF;
            5'd21:   v = 30'h000001FF;
            5'd22:   v = 30'h000000FF;
            5'd23:   v = 30'h0000007F;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

>>> design/ggc_ctrl.sv
module ggc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  ggc_pkg::t_dp_stat i_stat,
    output ggc_pkg::t_dp_cmd  o_cmd
);
    import ggc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_INIT  = 4'd2;
    localparam logic [3:0] S_ITER  = 4'd3;
    localparam logic [3:0] S_ROUND = 4'd4;
    localparam logic [3:0] S_WRAP  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.finished || i_stat.dup_step) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.mark_step = 1'b1;
                    if (i_stat.stop_cond) begin
                        o_cmd.set_stop = 1'b1;
                        n_state        = S_OUT;
                    end else begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.cordic_init = 1'b1;
                n_state           = S_ITER;
            end
            S_ITER: begin
                o_cmd.cordic_step = 1'b1;
                if (i_stat.iter_last) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round_err = 1'b1;
                n_state         = S_WRAP;
            end
            S_WRAP: begin
                if (i_stat.err_high || i_stat.err_low) begin
                    o_cmd.wrap_err = 1'b1;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mult = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> design/ggc_datapath.sv
module ggc_datapath #(
    parameter int CORDIC_ITERATIONS = ggc_pkg::CORDIC_ITERS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ggc_pkg::t_dp_cmd    i_cmd,
    output ggc_pkg::t_dp_stat   o_stat,
    input  logic [15:0]         i_heading_gain,
    input  logic [15:0]         i_speed_gain,
    input  logic [15:0]         i_speed_limit,
    input  logic [15:0]         i_arrive_radius,
    input  logic [14:0]         i_drive_window,
    input  logic [31:0]         i_step_number,
    input  logic signed [15:0]  i_pos_x,
    input  logic signed [15:0]  i_pos_y,
    input  logic signed [15:0]  i_heading_angle,
    input  logic signed [15:0]  i_target_x,
    input  logic signed [15:0]  i_target_y,
    input  logic [15:0]         i_target_distance,
    input  logic                i_arrived_flag,
    output logic [15:0]         o_linear_cmd,
    output logic signed [15:0]  o_angular_cmd,
    output logic                o_stop_flag
);
    import ggc_pkg::*;

    localparam int ITERS = (CORDIC_ITERATIONS > TAB_LEN) ? TAB_LEN : CORDIC_ITERATIONS;
    localparam int CNT_W = (ITERS > 1) ? $clog2(ITERS) : 1;

    logic [31:0]        r_step;
    logic signed [15:0] r_px, r_py, r_hd, r_tx, r_ty;
    logic [15:0]        r_dist;
    logic               r_arr;

    logic [31:0]        r_prev_step;
    logic               r_prev_valid;
    logic               r_finished;

    logic signed [27:0] r_x, r_y;
    logic signed [34:0] r_z;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_zero;

    logic signed [19:0] r_err;
    logic signed [32:0] r_pa;
    logic [31:0]        r_pl;
    logic               r_drive;

    logic [15:0]        r_res_lin;
    logic signed [15:0] r_res_ang;
    logic               r_res_stop;
    logic [15:0]        r_o_lin;
    logic signed [15:0] r_o_ang;
    logic               r_o_stop;

    logic signed [16:0] w_dx, w_dy;
    logic signed [27:0] w_x0, w_y0;
    logic signed [27:0] w_xs, w_ys;
    logic signed [34:0] w_tab;
    logic [34:0]        w_zabs, w_zsum;
    logic signed [19:0] w_q20, w_brg, w_err;
    logic signed [15:0] w_err16;
    logic [14:0]        w_mag;
    logic [32:0]        w_pabs, w_psum;
    logic signed [18:0] w_aq, w_ang;
    logic signed [15:0] w_ang_sat;
    logic [32:0]        w_lsum;
    logic [20:0]        w_lq;
    logic [15:0]        w_lin;

    assign w_dx = 17'(r_tx) - 17'(r_px);
    assign w_dy = 17'(r_ty) - 17'(r_py);
    assign w_x0 = 28'(w_dx) <<< 8;
    assign w_y0 = 28'(w_dy) <<< 8;

    assign w_xs  = r_x >>> r_cnt;
    assign w_ys  = r_y >>> r_cnt;
    assign w_tab = $signed({5'b00000, atan_tab(TAB_IDX_W'(r_cnt))});

    assign w_zabs = r_z[34] ? 35'(-r_z) : 35'(r_z);
    assign w_zsum = w_zabs + 35'd65536;
    assign w_q20  = $signed({2'b00, w_zsum[34:17]});
    assign w_brg  = r_zero ? 20'sd0 : (r_z[34] ? -w_q20 : w_q20);
    assign w_err  = w_brg - 20'(r_hd);

    assign w_err16 = r_err[15:0];
    assign w_mag   = r_err[19] ? 15'(-r_err) : 15'(r_err);

    assign w_pabs = r_pa[32] ? 33'(-r_pa) : 33'(r_pa);
    assign w_psum = w_pabs + 33'd16384;
    assign w_aq   = $signed({1'b0, w_psum[32:15]});
    assign w_ang  = r_pa[32] ? -w_aq : w_aq;

    always_comb begin
        if (w_ang > 19'sd32767) begin
            w_ang_sat = 16'sd32767;
        end else if (w_ang < -19'sd32768) begin
            w_ang_sat = -16'sd32768;
        end else begin
            w_ang_sat = w_ang[15:0];
        end
    end

    assign w_lsum = {1'b0, r_pl} + 33'd2048;
    assign w_lq   = w_lsum[32:12];

    always_comb begin
        if (!r_drive) begin
            w_lin = 16'd0;
        end else if (w_lq > {5'b00000, i_speed_limit}) begin
            w_lin = i_speed_limit;
        end else begin
            w_lin = w_lq[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_step  <= '0;
            r_prev_valid <= 1'b0;
            r_finished   <= 1'b0;
        end else begin
            if (i_cmd.mark_step) begin
                r_prev_step  <= r_step;
                r_prev_valid <= 1'b1;
            end
            if (i_cmd.set_stop) begin
                r_finished <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_step <= i_step_number;
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_hd   <= i_heading_angle;
            r_tx   <= i_target_x;
            r_ty   <= i_target_y;
            r_dist <= i_target_distance;
            r_arr  <= i_arrived_flag;
        end
        if (i_cmd.cordic_init) begin
            r_cnt  <= '0;
            r_zero <= (w_dx == 17'sd0) && (w_dy == 17'sd0);
            if (w_dx < 17'sd0) begin
                r_x <= -w_x0;
                r_y <= -w_y0;
                r_z <= (w_dy >= 17'sd0) ? PI_Q30 : -PI_Q30;
            end else begin
                r_x <= w_x0;
                r_y <= w_y0;
                r_z <= '0;
            end
        end
        if (i_cmd.cordic_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_y >= 28'sd0) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_tab;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_tab;
            end
        end
        if (i_cmd.round_err) begin
            r_err <= w_err;
        end
        if (i_cmd.wrap_err) begin
            if (r_err > PI_Q13) begin
                r_err <= r_err - TWO_PI_Q13;
            end else begin
                r_err <= r_err + TWO_PI_Q13;
            end
        end
        if (i_cmd.mult) begin
            r_pa    <= $signed({1'b0, i_heading_gain}) * 33'(w_err16);
            r_pl    <= i_speed_gain * r_dist;
            r_drive <= (w_mag < i_drive_window);
        end
        if (i_cmd.finish) begin
            r_res_lin  <= w_lin;
            r_res_ang  <= w_ang_sat;
            r_res_stop <= 1'b0;
        end
        if (i_cmd.set_stop) begin
            r_res_lin  <= '0;
            r_res_ang  <= '0;
            r_res_stop <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_o_lin  <= r_res_lin;
            r_o_ang  <= r_res_ang;
            r_o_stop <= r_res_stop;
        end
    end

    assign o_stat.finished  = r_finished;
    assign o_stat.dup_step  = r_prev_valid && (r_step == r_prev_step);
    assign o_stat.stop_cond = r_arr || (r_dist < i_arrive_radius);
    assign o_stat.iter_last = (r_cnt == CNT_W'(ITERS - 1));
    assign o_stat.err_high  = (r_err > PI_Q13);
    assign o_stat.err_low   = (r_err <= -PI_Q13);

    assign o_linear_cmd  = r_o_lin;
    assign o_angular_cmd = r_o_ang;
    assign o_stop_flag   = r_o_stop;

endmodule

>>> design/go_to_goal_heading_speed_control_core.sv
// Go-to-goal controller: turns a robot pose and goal into speed and turn commands.
// Input beats arrive on the s_axis channel: tdata carries the step number, the
// robot x, y and heading, the goal x and y and the goal distance; tuser carries
// the reached flag. A beat whose step number repeats the last one gives no output.
// A reached goal, or a distance below the arrive radius, gives one zero command
// with tlast set, after which all input beats are consumed silently until reset.
// Output beats leave on m_axis: tdata carries linear and angular commands.
// Each input beat passes through check, init, the CORDIC rotations, error rounding,
// the heading-error wrap check, multiply and finish, then waits for the output
// register; the iterative CORDIC atan2 runs one rotation per cycle. A stop beat goes
// from check straight to the output register, and dropped beats return to idle.
// The block works on one beat at a time; s_axis_tready is high only when idle.
// One output register holds a finished beat, so a new input beat is taken
// while the receiver stalls; its result then waits until the register frees.
// Gains and limits are written through the cfg port; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// Reset is synchronous and active low; it restores the default gains and
// forgets the last step number and the finished state.
module go_to_goal_heading_speed_control_core #(
    parameter int CORDIC_ITERATIONS = ggc_pkg::CORDIC_ITERS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // step_number, pos_x, pos_y, heading_angle, target_x, target_y, target_distance
    input  logic [127:0]                    s_axis_tdata,
    // arrived_flag
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // linear_cmd, angular_cmd
    output logic [31:0]                     m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            i_cfg_we,
    input  logic [ggc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ggc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ggc_pkg::*;

    logic [15:0] r_heading_gain;
    logic [15:0] r_speed_gain;
    logic [15:0] r_speed_limit;
    logic [15:0] r_arrive_radius;
    logic [14:0] r_drive_window;

    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    logic [15:0]        w_lin;
    logic signed [15:0] w_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading_gain  <= HEADING_GAIN_RST;
            r_speed_gain    <= SPEED_GAIN_RST;
            r_speed_limit   <= SPEED_LIMIT_RST;
            r_arrive_radius <= ARRIVE_RADIUS_RST;
            r_drive_window  <= DRIVE_WINDOW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HEADING_GAIN:  r_heading_gain  <= i_cfg_data;
                REG_SPEED_GAIN:    r_speed_gain    <= i_cfg_data;
                REG_SPEED_LIMIT:   r_speed_limit   <= i_cfg_data;
                REG_ARRIVE_RADIUS: r_arrive_radius <= i_cfg_data;
                REG_DRIVE_WINDOW:  r_drive_window  <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    ggc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ggc_datapath #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_heading_gain    (r_heading_gain),
        .i_speed_gain      (r_speed_gain),
        .i_speed_limit     (r_speed_limit),
        .i_arrive_radius   (r_arrive_radius),
        .i_drive_window    (r_drive_window),
        .i_step_number     (s_axis_tdata[31:0]),
        .i_pos_x           ($signed(s_axis_tdata[47:32])),
        .i_pos_y           ($signed(s_axis_tdata[63:48])),
        .i_heading_angle   ($signed(s_axis_tdata[79:64])),
        .i_target_x        ($signed(s_axis_tdata[95:80])),
        .i_target_y        ($signed(s_axis_tdata[111:96])),
        .i_target_distance (s_axis_tdata[127:112]),
        .i_arrived_flag    (s_axis_tuser),
        .o_linear_cmd      (w_lin),
        .o_angular_cmd     (w_ang),
        .o_stop_flag       (m_axis_tlast)
    );

    assign m_axis_tdata = {w_ang, w_lin};

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ggc_pkg::*;

    localparam int ROTATIONS     = (CORDIC_ITERS_DEF > 24) ? 24 : CORDIC_ITERS_DEF;
    localparam longint HALF_TURN_Q30 = 64'sd3373259426;
    localparam longint HALF_TURN_Q13 = 25736;
    localparam longint FULL_TURN_Q13 = 51472;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_BEATS   = 185;
    localparam int PRINT_CAP     = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    typedef struct packed {
        logic        [15:0] goal_dist;
        logic signed [15:0] ty;
        logic signed [15:0] tx;
        logic signed [15:0] hd;
        logic signed [15:0] py;
        logic signed [15:0] px;
        logic        [31:0] step;
    } pose_goal_t;

    typedef struct packed {
        logic       arrived;
        pose_goal_t f;
    } goal_beat_t;

    typedef struct packed {
        logic               stop;
        logic signed [15:0] angular;
        logic        [15:0] linear;
    } motion_cmd_t;

    typedef struct packed {
        goal_beat_t  beat;
        logic        typed;
        motion_cmd_t cmd;
    } plan_row_t;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [127:0]           s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [31:0]            m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    go_to_goal_heading_speed_control_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    longint atan_q30 [0:23] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
        64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    logic [15:0] turn_gain  = HEADING_GAIN_RST;
    logic [15:0] fwd_gain   = SPEED_GAIN_RST;
    logic [15:0] v_limit    = SPEED_LIMIT_RST;
    logic [15:0] r_arrive   = ARRIVE_RADIUS_RST;
    logic [14:0] w_drive    = DRIVE_WINDOW_RST;
    logic [31:0] ctl_prev_step  = '0;
    logic        ctl_prev_valid = 1'b0;
    logic        ctl_finished   = 1'b0;

    motion_cmd_t pending_cmds[$];
    plan_row_t   plan_rows[$];
    int mismatch_count   = 0;
    int commands_checked = 0;
    int beats_sent       = 0;
    int beats_dropped    = 0;
    int settings_used    = 1;
    int src_idle_pct     = 0;
    int sink_stall_pct   = 0;
    int hold_trig        = 0;
    int hold_seen        = 0;
    int hold_left        = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("go_to_goal_heading_speed_control_core verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH at command %0d: %s got %0d expected %0d",
                     commands_checked, what, got, want);
        mismatch_count++;
    endtask

    function automatic longint round_half_away(input longint v, input int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0)
            return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    // Vectoring CORDIC; the left half-plane is folded over by negating both deltas.
    function automatic longint goal_bearing(input longint dx, input longint dy);
        longint x, y, z, xs, ys;
        if (dx == 0 && dy == 0)
            return 0;
        x = dx * 256;
        y = dy * 256;
        z = 0;
        if (dx < 0) begin
            z = (dy >= 0) ? HALF_TURN_Q30 : -HALF_TURN_Q30;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ROTATIONS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_q30[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_q30[i];
            end
        end
        return round_half_away(z, 17);
    endfunction

    function automatic bit predict_command(input goal_beat_t b, output motion_cmd_t res);
        longint err, ang, mag, lin;
        res = '0;
        if (ctl_finished)
            return 1'b0;
        if (ctl_prev_valid && b.f.step == ctl_prev_step)
            return 1'b0;
        ctl_prev_step  = b.f.step;
        ctl_prev_valid = 1'b1;
        if (b.arrived || b.f.goal_dist < r_arrive) begin
            ctl_finished = 1'b1;
            res.stop = 1'b1;
            return 1'b1;
        end
        err = goal_bearing(longint'(b.f.tx) - longint'(b.f.px),
                           longint'(b.f.ty) - longint'(b.f.py)) - longint'(b.f.hd);
        while (err > HALF_TURN_Q13)
            err -= FULL_TURN_Q13;
        while (err <= -HALF_TURN_Q13)
            err += FULL_TURN_Q13;
        ang = round_half_away(longint'(turn_gain) * err, 15);
        if (ang > 32767)
            ang = 32767;
        if (ang < -32768)
            ang = -32768;
        mag = (err < 0) ? -err : err;
        lin = 0;
        if (mag < longint'(w_drive)) begin
            lin = (longint'(fwd_gain) * longint'(b.f.goal_dist) + 2048) >>> 12;
            if (lin > longint'(v_limit))
                lin = longint'(v_limit);
        end
        res.linear  = lin[15:0];
        res.angular = ang[15:0];
        return 1'b1;
    endfunction

    function automatic void add_row(input logic [31:0] step, input int px, input int py,
                                    input int hd, input int tx, input int ty, input int gdist,
                                    input logic arrived, input logic typed,
                                    input int lin, input int ang);
        plan_row_t r;
        r = '0;
        r.beat.f.step = step;
        r.beat.f.px   = 16'(px);
        r.beat.f.py   = 16'(py);
        r.beat.f.hd   = 16'(hd);
        r.beat.f.tx   = 16'(tx);
        r.beat.f.ty   = 16'(ty);
        r.beat.f.goal_dist = 16'(gdist);
        r.beat.arrived = arrived;
        r.typed       = typed;
        r.cmd.linear  = 16'(lin);
        r.cmd.angular = 16'(ang);
        plan_rows.push_back(r);
    endfunction

    // Mostly fresh steps with a goal in view; some repeats carry noise and the reached flag.
    function automatic goal_beat_t random_beat();
        goal_beat_t b;
        int r, d;
        b = '0;
        r = $urandom_range(99);
        b.f.px = 16'($urandom());
        b.f.py = 16'($urandom());
        if ($urandom_range(1)) begin
            b.f.tx = 16'($urandom());
            b.f.ty = 16'($urandom());
        end else begin
            b.f.tx = 16'(int'(b.f.px) + int'($urandom_range(1024)) - 512);
            b.f.ty = 16'(int'(b.f.py) + int'($urandom_range(1024)) - 512);
        end
        if ($urandom_range(19) == 0) begin
            b.f.tx = b.f.px;
            b.f.ty = b.f.py;
        end
        if ($urandom_range(99) < 40)
            b.f.hd = 16'(goal_bearing(longint'(b.f.tx) - longint'(b.f.px),
                                      longint'(b.f.ty) - longint'(b.f.py))
                         + longint'($urandom_range(6000)) - 3000);
        else
            b.f.hd = 16'($urandom());
        if (r < 8) begin
            b.f.step      = ctl_prev_step;
            b.f.goal_dist = 16'($urandom());
            b.arrived     = 1'($urandom_range(1));
        end else begin
            b.f.step = (r < 15) ? 32'($urandom()) : ctl_prev_step + 32'd1;
            if ($urandom_range(1))
                d = int'(r_arrive) + int'($urandom_range(600));
            else
                d = int'($urandom_range(65535, r_arrive));
            if (d > 65535)
                d = 65535;
            b.f.goal_dist = 16'(d);
        end
        return b;
    endfunction

    task automatic send_beat(input goal_beat_t b, input logic typed, input motion_cmd_t typed_cmd);
        motion_cmd_t want;
        bit gives;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b.f;
        s_axis_tuser  <= b.arrived;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        gives = predict_command(b, want);
        beats_sent++;
        if (!gives)
            beats_dropped++;
        else
            pending_cmds.push_back(typed ? typed_cmd : want);
    endtask

    task automatic wait_for_idle();
        while (pending_cmds.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            REG_HEADING_GAIN:  turn_gain  = value;
            REG_SPEED_GAIN:    fwd_gain   = value;
            REG_SPEED_LIMIT:   v_limit    = value;
            REG_ARRIVE_RADIUS: r_arrive   = value;
            REG_DRIVE_WINDOW:  w_drive    = value[14:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_gains(input logic [15:0] hg, input logic [15:0] sg, input logic [15:0] lim,
                              input logic [15:0] rad, input logic [15:0] win);
        write_reg(REG_HEADING_GAIN, hg);
        write_reg(REG_SPEED_GAIN, sg);
        write_reg(REG_SPEED_LIMIT, lim);
        write_reg(REG_ARRIVE_RADIUS, rad);
        write_reg(REG_DRIVE_WINDOW, win);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct, input bit hold);
        src_idle_pct = src_pct;
        sink_stall_pct <= sink_pct;
        if (hold)
            hold_trig <= hold_trig + 1;
        repeat (PHASE_BEATS)
            send_beat(random_beat(), 1'b0, '0);
        s_axis_tvalid <= 1'b0;
        wait_for_idle();
    endtask

    // The receiver holds off for a long stretch whenever the trigger count moves.
    always @(posedge i_clk) begin
        if (hold_trig != hold_seen) begin
            hold_seen     <= hold_trig;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin : watch_commands
        motion_cmd_t got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tlast, m_axis_tdata};
            if (pending_cmds.size() == 0) begin
                report_mismatch("command with nothing expected", got, 0);
            end else begin
                want = pending_cmds.pop_front();
                if (got.linear !== want.linear)
                    report_mismatch("linear_cmd", got.linear, want.linear);
                if (got.angular !== want.angular)
                    report_mismatch("angular_cmd", got.angular, want.angular);
                if (got.stop !== want.stop)
                    report_mismatch("stop_flag", got.stop, want.stop);
            end
            commands_checked++;
        end
    end

    initial begin : stimulus
        goal_beat_t b;
        motion_cmd_t stop_cmd;
        stop_cmd = '0;
        stop_cmd.stop = 1'b1;

        add_row(0, 0, 0, 0, 0, 0, 256, 0, 1, 128, 0);
        add_row(0, 0, 0, 0, 0, 0, 256, 1, 0, 0, 0);
        add_row(1, 0, 0, 0, 0, 0, 65535, 0, 1, 256, 0);
        add_row(2, 0, 0, 1000, 0, 0, 256, 0, 1, 128, -188);
        add_row(3, 0, 0, -1000, 0, 0, 256, 0, 1, 128, 188);
        add_row(4, 0, 0, 32767, 0, 0, 300, 0, 0, 0, 0);
        add_row(5, 0, 0, -32768, 0, 0, 300, 0, 0, 0, 0);
        add_row(6, 0, 0, 25736, 0, 0, 300, 0, 0, 0, 0);
        add_row(7, 0, 0, -25736, 0, 0, 300, 0, 0, 0, 0);
        add_row(8, 0, 0, 0, 256, 0, 1000, 0, 0, 0, 0);
        add_row(9, 0, 0, 0, -256, 0, 1000, 0, 0, 0, 0);
        add_row(10, 0, 0, 0, -256, -1, 1000, 0, 0, 0, 0);
        add_row(11, 0, 0, 0, 0, 256, 1000, 0, 0, 0, 0);
        add_row(12, 0, 0, 0, 0, -256, 1000, 0, 0, 0, 0);
        add_row(13, -32768, 32767, 12000, 32767, -32768, 65535, 0, 0, 0, 0);
        add_row(14, 32767, -32768, -12000, -32768, 32767, 128, 0, 0, 0, 0);
        add_row(32'hFFFFFFFF, 100, -100, 0, 612, -612, 512, 0, 0, 0, 0);
        add_row(32'hFFFFFFFF, 100, -100, 0, 612, -612, 512, 1, 0, 0, 0);
        add_row(32'h00000000, -5000, 3000, 20000, 4000, -2000, 700, 0, 0, 0, 0);
        add_row(32'h55555555, 21845, -21846, -21846, -21846, 21845, 21845, 0, 0, 0, 0);
        add_row(32'hAAAAAAAA, -21846, 21845, 21845, 21845, -21846, 43690, 0, 0, 0, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan_rows[k])
            send_beat(plan_rows[k].beat, plan_rows[k].typed, plan_rows[k].cmd);
        s_axis_tvalid <= 1'b0;
        wait_for_idle();

        run_phase(0, 0, 1'b1);

        write_reg(CFG_IDX_SPARE_LO, 16'hFFFF);
        load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd25736);
        run_phase(80, 0, 1'b0);

        load_gains(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_phase(0, 80, 1'b0);

        // Bit 15 of the window write must be dropped by the block.
        load_gains(16'($urandom()), 16'($urandom()), 16'($urandom()),
                   16'($urandom_range(512)),
                   {1'b1, 15'($urandom_range(25736))});
        run_phase(13, 13, 1'b1);

        load_gains(16'd4096, 16'd4096, 16'd2560, 16'd1, 16'd12868);
        run_phase(0, 0, 1'b0);

        // Widest radius: only a full-scale distance keeps the goal open, then one stop.
        write_reg(CFG_IDX_SPARE_HI, 16'h0000);
        load_gains(16'd6144, 16'd2048, 16'd256, 16'hFFFF, 16'd2458);
        repeat (2) begin
            b = random_beat();
            b.arrived     = 1'b0;
            b.f.step      = ctl_prev_step + 32'd1;
            b.f.goal_dist = 16'hFFFF;
            send_beat(b, 1'b0, '0);
        end
        b = random_beat();
        b.arrived     = 1'b0;
        b.f.step      = ctl_prev_step + 32'd1;
        b.f.goal_dist = 16'd1000;
        send_beat(b, 1'b1, stop_cmd);
        repeat (3) begin
            b = random_beat();
            b.arrived     = 1'($urandom_range(1));
            b.f.step      = $urandom();
            b.f.goal_dist = $urandom_range(3) == 0 ? 16'd0 : 16'($urandom());
            send_beat(b, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        wait_for_idle();

        if (pending_cmds.size() != 0)
            report_mismatch("commands never delivered", pending_cmds.size(), 0);
        $display("Sent %0d input beats (%0d skipped as repeats or after the stop); %0d commands",
                 beats_sent, beats_dropped, commands_checked);
        $display("checked over %0d gain settings, with long output hold-offs and a final stop.",
                 settings_used);
        if (mismatch_count == 0) begin
            $display("go_to_goal_heading_speed_control_core verification clean");
        end else begin
            $display("go_to_goal_heading_speed_control_core verification failed");
        end
        $finish;
    end

endmodule
